[hw/rtl/tbsf_pkg.sv]
// ============================================================================
// Telemetry byte-stuffing framer package
// Shared constants, the command type passed from the front to the back, and
// default sizes.
// ============================================================================
package tbsf_pkg;

    localparam int USER_SLOTS_DEF = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] MSG_HEADER   = 8'h5E;
    localparam logic [7:0] MSG_ESCAPE   = 8'h5D;
    localparam logic [7:0] MSG_XOR      = 8'h60;
    localparam logic [7:0] FRAME_FLAG   = 8'h7E;
    localparam logic [7:0] FRAME_ESCAPE = 8'h7D;
    localparam logic [7:0] FRAME_XOR    = 8'h20;
    localparam logic [7:0] FRAME_ID     = 8'hFD;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_OUTER = 2'd1,
        KIND_INNER = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       flush;
    } t_cmd;

endpackage

[hw/rtl/tbsf_if.sv]
// ============================================================================
// Telemetry byte-stuffing framer channels
// Input beat channel and output beat channel with valid/ready handshake.
// ============================================================================
interface tbsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       message_start;
    logic       flush;

    modport source (output valid, output data_byte, output message_start,
                    output flush, input ready);
    modport sink   (input valid, input data_byte, input message_start,
                    input flush, output ready);
endinterface

interface tbsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last,
                    input ready);
    modport sink   (input valid, input frame_byte, input frame_last,
                    output ready);
endinterface

[hw/rtl/tbsf_front.sv]
// ============================================================================
// Telemetry byte-stuffing framer front end
// Accepts input beats and classifies each byte into a registered command.
// ============================================================================
module tbsf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tbsf_in_if.sink         i_in,
    output tbsf_pkg::t_cmd  o_cmd,
    output logic            o_cmd_vld,
    input  logic            i_cmd_rdy
);

    logic           r_vld;
    tbsf_pkg::t_cmd r_cmd;
    tbsf_pkg::t_cmd n_cmd;
    logic           take;

    assign i_in.ready = !r_vld || i_cmd_rdy;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_cmd.data  = i_in.data_byte;
        n_cmd.flush = i_in.flush;
        if (!i_in.message_start && (i_in.data_byte == tbsf_pkg::MSG_HEADER ||
                                    i_in.data_byte == tbsf_pkg::MSG_ESCAPE)) begin
            n_cmd.kind = tbsf_pkg::KIND_INNER;
        end else if (i_in.data_byte == tbsf_pkg::FRAME_FLAG ||
                     i_in.data_byte == tbsf_pkg::FRAME_ESCAPE) begin
            n_cmd.kind = tbsf_pkg::KIND_OUTER;
        end else begin
            n_cmd.kind = tbsf_pkg::KIND_PLAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_cmd_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd     = r_cmd;
    assign o_cmd_vld = r_vld;

endmodule

[hw/rtl/tbsf_queue.sv]
// ============================================================================
// Telemetry byte-stuffing framer command queue
// Short first-in first-out buffer between the front end and the back end.
// ============================================================================
module tbsf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tbsf_pkg::t_cmd  i_cmd,
    input  logic            i_push,
    output logic            o_rdy,
    output tbsf_pkg::t_cmd  o_cmd,
    output logic            o_vld,
    input  logic            i_pop
);

    localparam int PW = $clog2(tbsf_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tbsf_pkg::QUEUE_DEPTH + 1);

    tbsf_pkg::t_cmd r_mem [tbsf_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_rdy   = r_cnt != CW'(tbsf_pkg::QUEUE_DEPTH);
    assign o_vld   = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_rdy;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/tbsf_back.sv]
// ============================================================================
// Telemetry byte-stuffing framer back end
// Places stuffed bytes into the user slots and streams out finished frames.
// ============================================================================
module tbsf_back #(
    parameter int USER_SLOTS = tbsf_pkg::USER_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tbsf_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_vld,
    output logic            o_cmd_rdy,
    tbsf_out_if.source      o_out
);

    localparam int FLEN = USER_SLOTS + 5;
    localparam int CW   = $clog2(USER_SLOTS + 1);
    localparam int IW   = $clog2(FLEN);

    typedef enum logic [1:0] {
        ST_PLACE = 2'b01,
        ST_EMIT  = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_unit, n_unit;
    logic [IW-1:0]   r_idx, n_idx;
    logic [7:0]      r_slot [USER_SLOTS];
    logic [7:0]      n_slot [USER_SLOTS];
    logic            r_out_vld, n_out_vld;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;

    logic [7:0]      u_b0;
    logic [7:0]      u_b1;
    logic            u_pair;
    logic            u_last;
    logic [CW:0]     cnt_sum;
    logic            fits;
    logic [7:0]      f_byte;
    logic            out_adv;
    logic            f_last;

    always_comb begin
        u_b1 = '0;
        unique case (i_cmd.kind)
            tbsf_pkg::KIND_INNER: begin
                u_b0   = r_unit ? (i_cmd.data ^ tbsf_pkg::MSG_XOR) : tbsf_pkg::MSG_ESCAPE;
                u_pair = 1'b0;
                u_last = r_unit;
            end
            tbsf_pkg::KIND_OUTER: begin
                u_b0   = tbsf_pkg::FRAME_ESCAPE;
                u_b1   = i_cmd.data ^ tbsf_pkg::FRAME_XOR;
                u_pair = 1'b1;
                u_last = 1'b1;
            end
            default: begin
                u_b0   = i_cmd.data;
                u_pair = 1'b0;
                u_last = 1'b1;
            end
        endcase
    end

    assign cnt_sum = {1'b0, r_cnt} + (u_pair ? (CW+1)'(2) : (CW+1)'(1));
    assign fits    = cnt_sum <= (CW+1)'(USER_SLOTS);
    assign f_last  = r_idx == IW'(FLEN - 1);

    always_comb begin
        f_byte = '0;
        if (r_idx == IW'(0) || f_last) begin
            f_byte = tbsf_pkg::FRAME_FLAG;
        end else if (r_idx == IW'(1)) begin
            f_byte = tbsf_pkg::FRAME_ID;
        end else if (r_idx == IW'(2)) begin
            f_byte = 8'(r_cnt);
        end
        for (int i = 0; i < USER_SLOTS; i++) begin
            if (r_idx == IW'(i + 4) && CW'(i) < r_cnt) begin
                f_byte = r_slot[i];
            end
        end
    end

    assign out_adv = !r_out_vld || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_unit     = r_unit;
        n_idx      = r_idx;
        n_slot     = r_slot;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        o_cmd_rdy  = 1'b0;
        unique case (r_state)
            ST_PLACE: begin
                if (i_cmd_vld) begin
                    if (!fits) begin
                        n_state = ST_EMIT;
                        n_idx   = '0;
                    end else begin
                        for (int i = 0; i < USER_SLOTS; i++) begin
                            if (CW'(i) == r_cnt) begin
                                n_slot[i] = u_b0;
                            end
                            if (u_pair && CW'(i) == r_cnt + CW'(1)) begin
                                n_slot[i] = u_b1;
                            end
                        end
                        n_cnt = cnt_sum[CW-1:0];
                        if (u_last) begin
                            n_unit    = 1'b0;
                            o_cmd_rdy = 1'b1;
                            if (i_cmd.flush) begin
                                n_state = ST_EMIT;
                                n_idx   = '0;
                            end
                        end else begin
                            n_unit = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_adv) begin
                    n_out_vld  = 1'b1;
                    n_out_byte = f_byte;
                    n_out_last = f_last;
                    if (f_last) begin
                        n_cnt   = '0;
                        n_state = ST_PLACE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_PLACE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_PLACE;
            r_cnt     <= '0;
            r_unit    <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_unit    <= n_unit;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.frame_last = r_out_last;

endmodule

[hw/rtl/telemetry_byte_stuff_framer.sv]
// ============================================================================
// Telemetry byte-stuffing framer
// Two-level byte stuffing of message bytes into fixed-size user frames.
// ============================================================================
// Each accepted byte is classified by the front end and queued; the back end
// places one stuffed unit per cycle while a command waits and no frame is
// streaming (an inner-escaped byte as an escape unit, then its XORed byte;
// any other byte as one unit) and streams a frame of USER_SLOTS+5 bytes at
// one beat per cycle while the output is ready, whenever the next unit does
// not fit or a flush asks for it. At six slots the back end sets the pace,
// placing and emitting in turn: it fills the slots, finds the frame full and
// streams eleven bytes. The front register and a two-entry command queue absorb bursts.
module telemetry_byte_stuff_framer #(
    parameter int USER_SLOTS = tbsf_pkg::USER_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbsf_in_if.sink     i_in,
    tbsf_out_if.source  o_out
);

    tbsf_pkg::t_cmd front_cmd;
    logic           front_vld;
    logic           q_rdy;
    tbsf_pkg::t_cmd q_cmd;
    logic           q_vld;
    logic           q_pop;

    tbsf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_cmd     (front_cmd),
        .o_cmd_vld (front_vld),
        .i_cmd_rdy (q_rdy)
    );

    tbsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_push  (front_vld),
        .o_rdy   (q_rdy),
        .o_cmd   (q_cmd),
        .o_vld   (q_vld),
        .i_pop   (q_pop)
    );

    tbsf_back #(
        .USER_SLOTS (USER_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .i_cmd_vld (q_vld),
        .o_cmd_rdy (q_pop),
        .o_out     (o_out)
    );

    a_last_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_last |-> o_out.frame_byte == tbsf_pkg::FRAME_FLAG)
        else $error("closing frame byte is not the flag");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld)
        else $error("back end took a command from an empty queue");

    a_flag_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.frame_last ##1 o_out.valid
        |-> o_out.frame_byte == tbsf_pkg::FRAME_FLAG)
        else $error("frame after a closing flag does not open with a flag");

endmodule
